// ===== hw/rtl/mtib_pkg.sv =====
// package for the threshold and pack blitter
// shared types, register index codes and screen geometry defaults
// no dependencies
`default_nettype none

package mtib_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 720;
  localparam int unsigned SCREEN_HEIGHT_DEF = 348;
  localparam int unsigned LINE_PITCH_DEF    = 90;
  localparam int unsigned BANK_BYTES_DEF    = 8192;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 16;
  // wide enough for bank offset plus row offset plus pitch at the largest geometry
  localparam int unsigned OFF_W   = 18;
  localparam int unsigned VRAM_SIZE = 32768;
  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd128;

  typedef enum logic [CIDX_W-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_ROW_STRIDE      = 2'd2,
    CFG_LEVEL_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [DIM_W-1:0] row_stride;
    logic [PIX_W-1:0] level_threshold;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] grey_pixel;
    logic             frame_start;
  } pix_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mtib_pix_if.sv =====
// pixel stream channel: valid, ready, grey byte and frame start
// depends on mtib_pkg
`default_nettype none

interface mtib_pix_if;
  logic                      valid;
  logic                      ready;
  logic [mtib_pkg::PIX_W-1:0] grey_pixel;
  logic                      frame_start;

  modport source (output valid, output grey_pixel, output frame_start, input ready);
  modport sink   (input valid, input grey_pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mtib_wr_if.sv =====
// frame buffer write channel: valid, ready, address, byte and last flag
// depends on mtib_pkg
`default_nettype none

interface mtib_wr_if;
  logic                        valid;
  logic                        ready;
  logic [mtib_pkg::ADDR_W-1:0] vram_address;
  logic [mtib_pkg::PIX_W-1:0]  vram_byte;
  logic                        last_write;

  modport source (output valid, output vram_address, output vram_byte, output last_write,
                  input ready);
  modport sink   (input valid, input vram_address, input vram_byte, input last_write,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mtib_cfg_if.sv =====
// configuration write channel: valid, ready, register index and data
// depends on mtib_pkg
`default_nettype none

interface mtib_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mtib_pkg::CIDX_W-1:0]  index;
  logic [mtib_pkg::CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mono_threshold_interlaced_blit.sv =====
// top level of the 1 bpp threshold blitter for a four bank interlaced frame buffer
// depends on mtib_pkg, the channel interfaces, mtib_cfg_regs, mtib_in_reg, mtib_pack
//
// usage
//   in_ch carries one grey source byte per beat in raster order, row_stride
//   bytes per row; frame_start on a beat restarts the counters at that byte
//   out_ch carries frame buffer writes: address, packed byte (leftmost pixel
//   in bit 7) and last_write on the final write of the frame; one write per
//   eight used pixels or at the end of a used row, none for dropped bytes
//   cfg_ch writes frame_width, frame_height, row_stride and level_threshold
//   by index; always ready, write only while the stream is idle
//   the beat that completes a write passes the input register, then the write register
//   throughput: one input beat per cycle while out_ch is ready, set by the
//   single compute stage between the input register and the write register
//   reset: valid flags, counters and config clear, threshold returns to 128, no writes pending
//   a stalled receiver holds the write register; the input register then
//   fills and in_ch.ready drops until the write is taken
`default_nettype none

module mono_threshold_interlaced_blit #(
  parameter int unsigned SCREEN_WIDTH  = mtib_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mtib_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned LINE_PITCH    = mtib_pkg::LINE_PITCH_DEF,
  parameter int unsigned BANK_BYTES    = mtib_pkg::BANK_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mtib_pix_if.sink  in_ch,
  mtib_wr_if.source out_ch,
  mtib_cfg_if.sink  cfg_ch
);

  mtib_pkg::cfg_t      cfg;
  mtib_pkg::pix_beat_t beat;
  logic                advance;

  mtib_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mtib_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .beat    (beat)
  );

  mtib_pack #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .LINE_PITCH    (LINE_PITCH),
    .BANK_BYTES    (BANK_BYTES)
  ) u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .beat    (beat),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mtib_cfg_regs.sv =====
// configuration register file, one write per beat, always ready
// depends on mtib_pkg and mtib_cfg_if
`default_nettype none

module mtib_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mtib_cfg_if.sink         cfg_ch,
  output mtib_pkg::cfg_t   cfg
);

  mtib_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (mtib_pkg::cfg_idx_t'(cfg_ch.index))
        mtib_pkg::CFG_FRAME_WIDTH:     cfg_nxt.frame_width  = cfg_ch.data;
        mtib_pkg::CFG_FRAME_HEIGHT:    cfg_nxt.frame_height = cfg_ch.data;
        mtib_pkg::CFG_ROW_STRIDE:      cfg_nxt.row_stride   = cfg_ch.data;
        mtib_pkg::CFG_LEVEL_THRESHOLD:
          cfg_nxt.level_threshold = cfg_ch.data[mtib_pkg::PIX_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width     <= '0;
      cfg_r.frame_height    <= '0;
      cfg_r.row_stride      <= '0;
      cfg_r.level_threshold <= mtib_pkg::THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtib_in_reg.sv =====
// input register stage for the pixel stream
// depends on mtib_pkg and mtib_pix_if
`default_nettype none

module mtib_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mtib_pix_if.sink           in_ch,
  input  wire logic          advance,
  output mtib_pkg::pix_beat_t beat
);

  logic                        valid_r, valid_nxt;
  logic [mtib_pkg::PIX_W-1:0]  grey_r;
  logic                        start_r;
  logic                        take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      grey_r  <= in_ch.grey_pixel;
      start_r <= in_ch.frame_start;
    end
  end

  assign beat.valid       = valid_r;
  assign beat.grey_pixel  = grey_r;
  assign beat.frame_start = start_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mtib_pack.sv =====
// threshold, bit packing, raster counters, address generation and write register
// depends on mtib_pkg and mtib_wr_if
`default_nettype none

module mtib_pack #(
  parameter int unsigned SCREEN_WIDTH  = mtib_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mtib_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned LINE_PITCH    = mtib_pkg::LINE_PITCH_DEF,
  parameter int unsigned BANK_BYTES    = mtib_pkg::BANK_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mtib_pkg::cfg_t      cfg,
  input  wire mtib_pkg::pix_beat_t beat,
  output logic                     advance,
  mtib_wr_if.source                out_ch
);

  localparam int unsigned DW  = mtib_pkg::DIM_W;
  localparam int unsigned OW  = mtib_pkg::OFF_W;
  localparam int unsigned YW  = $clog2(SCREEN_HEIGHT);
  localparam logic [DW-1:0]  SW_C    = DW'(SCREEN_WIDTH);
  localparam logic [DW-1:0]  SH_C    = DW'(SCREEN_HEIGHT);
  localparam logic [OW-1:0]  PITCH_C = OW'(LINE_PITCH);
  localparam logic [OW-1:0]  BANK_C  = OW'(BANK_BYTES);
  localparam logic [OW-1:0]  VRAM_C  = OW'(mtib_pkg::VRAM_SIZE);

  logic [DW-1:0]              col_r, col_nxt;
  logic [DW-1:0]              row_r, row_nxt;
  logic [mtib_pkg::PIX_W-1:0] bits_r, bits_nxt;

  logic                        wr_valid_r, wr_valid_nxt;
  logic [mtib_pkg::ADDR_W-1:0] wr_addr_r;
  logic [mtib_pkg::PIX_W-1:0]  wr_byte_r;
  logic                        wr_last_r;

  logic                        fire;
  logic [DW-1:0]               x, y, used_w, used_h;
  logic [mtib_pkg::PIX_W-1:0]  bits_src, bits_or;
  logic [DW:0]                 x_inc, y_inc;
  logic                        in_area, lit, byte_done, emit, last;
  logic [OW-1:0]               y_ext, off, addr_sum;

  assign advance = !wr_valid_r || out_ch.ready;
  assign fire    = beat.valid && advance;

  always_comb begin
    x        = beat.frame_start ? '0 : col_r;
    y        = beat.frame_start ? '0 : row_r;
    bits_src = beat.frame_start ? '0 : bits_r;

    used_w = (cfg.frame_width < SW_C) ? cfg.frame_width : SW_C;
    used_w = (cfg.row_stride < used_w) ? cfg.row_stride : used_w;
    used_h = (cfg.frame_height < SH_C) ? cfg.frame_height : SH_C;

    x_inc = {1'b0, x} + 1'b1;
    y_inc = {1'b0, y} + 1'b1;

    in_area   = (x < used_w) && (y < used_h);
    lit       = beat.grey_pixel >= cfg.level_threshold;
    bits_or   = bits_src | (mtib_pkg::PIX_W'(lit) << (~x[2:0]));
    byte_done = (x[2:0] == 3'b111) || (x_inc == {1'b0, used_w});

    // y is below the screen height whenever it is used for an address
    y_ext    = OW'(y[YW-1:0]);
    off      = OW'(y_ext[1:0]) * BANK_C + (y_ext >> 2) * PITCH_C;
    addr_sum = off + OW'(x >> 3);
    emit     = in_area && byte_done && (off + PITCH_C <= VRAM_C);
    last     = (y_inc == {1'b0, used_h}) && (x_inc == {1'b0, used_w});

    col_nxt  = col_r;
    row_nxt  = row_r;
    bits_nxt = bits_r;
    if (fire) begin
      if (cfg.row_stride == '0) begin
        col_nxt  = x;
        row_nxt  = y;
        bits_nxt = bits_src;
      end else begin
        bits_nxt = bits_src;
        if (in_area) begin
          bits_nxt = byte_done ? '0 : bits_or;
        end
        if (x_inc >= {1'b0, cfg.row_stride}) begin
          col_nxt = '0;
          row_nxt = (y == '1) ? y : y + 1'b1;
        end else begin
          col_nxt = x_inc[DW-1:0];
          row_nxt = y;
        end
      end
    end

    wr_valid_nxt = wr_valid_r;
    if (advance) begin
      wr_valid_nxt = beat.valid && (cfg.row_stride != '0) && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      bits_r     <= '0;
      wr_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      bits_r     <= bits_nxt;
      wr_valid_r <= wr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      wr_addr_r <= addr_sum[mtib_pkg::ADDR_W-1:0];
      wr_byte_r <= bits_or;
      wr_last_r <= last;
    end
  end

  assign out_ch.valid        = wr_valid_r;
  assign out_ch.vram_address = wr_addr_r;
  assign out_ch.vram_byte    = wr_byte_r;
  assign out_ch.last_write   = wr_last_r;

endmodule

`default_nettype wire
